@@ sv/fixed_word_exchange_sorter_core_defines.svh @@
// Assertion macros shared by the sorter checker.
// Each macro expects clk_i and rst_ni in scope.
`ifndef FIXED_WORD_EXCHANGE_SORTER_CORE_DEFINES_SVH
`define FIXED_WORD_EXCHANGE_SORTER_CORE_DEFINES_SVH

// Same-cycle implication
`define FWES_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define FWES_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/fwes_pkg.sv @@
`default_nettype none

package fwes_pkg;

  // Fixed field width of one packed word
  localparam int WordW = 48;

  // Default sizing
  localparam int MaxWordsDef  = 16;
  localparam int WordCharsDef = 6;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic             last;
  } in_t;

  typedef struct packed {
    logic [WordW-1:0] sorted_word;
    logic             end_of_batch;
    logic             words_dropped;
  } out_t;

endpackage

`default_nettype wire

@@ sv/fwes_ram.sv @@
`default_nettype none

module fwes_ram #(
  parameter int Width = fwes_pkg::WordW,
  parameter int Depth = fwes_pkg::MaxWordsDef
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write one entry, read one entry, registered read data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ sv/fixed_word_exchange_sorter_core.sv @@
// Load: one word per cycle while no batch is in progress; the last word starts the sort,
//   or goes straight to emit when fewer than two words are stored. Sort: for n >= 2 stored
//   words, one compare per cycle within each pass on the single read port of the word RAM.
// Emit: read in S_ERD, registered in S_EOUT; one result per cycle unless stalled.
// Reset clears control state, fill count and drop flag; the word RAM is not cleared.
`default_nettype none

module fixed_word_exchange_sorter_core #(
  parameter int MAX_WORDS  = fwes_pkg::MaxWordsDef,
  parameter int WORD_CHARS = fwes_pkg::WordCharsDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire fwes_pkg::in_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output fwes_pkg::out_t     out_data_o
);

  localparam int AW = $clog2(MAX_WORDS);
  localparam int CW = $clog2(MAX_WORDS + 1);
  localparam int WW = fwes_pkg::WordW;
  localparam int MaskBits = (8 * WORD_CHARS >= WW) ? WW : 8 * WORD_CHARS;
  localparam logic [WW-1:0] WordMask = {WW{1'b1}} >> (WW - MaskBits);

  typedef enum logic [2:0] {
    S_LOAD,
    S_PIV,
    S_PLD,
    S_CMP,
    S_WBA,
    S_ERD,
    S_EOUT
  } state_e;

  state_e         state_q, state_d;
  logic [CW-1:0]  count_q, count_d;
  logic           ovf_q, ovf_d;
  logic [AW-1:0]  a_q, a_d;
  logic [AW-1:0]  b_q, b_d;
  logic [AW-1:0]  k_q, k_d;
  logic [WW-1:0]  cur_q, cur_d;
  logic           out_valid_q, out_valid_d;
  fwes_pkg::out_t out_q, out_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [WW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [WW-1:0] ram_rdata;

  logic          in_fire;
  logic          out_free;
  logic          cnt_full;
  logic [CW-1:0] count_new;
  logic          eob;

  fwes_ram #(
    .Width (WW),
    .Depth (MAX_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o  = (state_q != S_LOAD);
  assign in_fire     = (state_q == S_LOAD) && in_valid_i;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cnt_full    = (count_q == CW'(MAX_WORDS));
  assign count_new   = cnt_full ? count_q : count_q + CW'(1);
  assign eob         = (CW'(k_q) + CW'(1) == count_q);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Sequence load, sort passes and emit around the word RAM
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    a_d         = a_q;
    b_d         = b_q;
    k_d         = k_q;
    cur_d       = cur_q;
    out_d       = out_q;
    out_valid_d = (out_valid_q && out_stall_i);
    ram_we      = 1'b0;
    ram_waddr   = a_q;
    ram_wdata   = cur_q;
    ram_raddr   = a_q;

    unique case (state_q)
      S_LOAD: begin
        if (in_fire) begin
          // Store the word, or drop it when the store is full
          if (!cnt_full) begin
            ram_we    = 1'b1;
            ram_waddr = count_q[AW-1:0];
            ram_wdata = in_data_i.word & WordMask;
          end else begin
            ovf_d = 1'b1;
          end
          count_d = count_new;
          if (in_data_i.last) begin
            a_d = '0;
            k_d = '0;
            state_d = (count_new >= CW'(2)) ? S_PIV : S_ERD;
          end
        end
      end
      S_PIV: begin
        ram_raddr = a_q;
        b_d       = a_q + AW'(1);
        state_d   = S_PLD;
      end
      S_PLD: begin
        // Latch the pivot and fetch the first partner
        cur_d     = ram_rdata;
        ram_raddr = b_q;
        state_d   = S_CMP;
      end
      S_CMP: begin
        // Exchange when the pivot is larger than the partner
        if (cur_q > ram_rdata) begin
          ram_we    = 1'b1;
          ram_waddr = b_q;
          ram_wdata = cur_q;
          cur_d     = ram_rdata;
        end
        if (CW'(b_q) + CW'(1) == count_q) begin
          state_d = S_WBA;
        end else begin
          b_d       = b_q + AW'(1);
          ram_raddr = b_q + AW'(1);
        end
      end
      S_WBA: begin
        // Write back the pass minimum and start the next pass, or emit after the last pass
        ram_we    = 1'b1;
        ram_waddr = a_q;
        ram_wdata = cur_q;
        if (CW'(a_q) + CW'(2) == count_q) begin
          k_d     = '0;
          state_d = S_ERD;
        end else begin
          a_d       = a_q + AW'(1);
          b_d       = a_q + AW'(2);
          ram_raddr = a_q + AW'(1);
          state_d   = S_PLD;
        end
      end
      S_ERD: begin
        ram_raddr = k_q;
        state_d   = S_EOUT;
      end
      S_EOUT: begin
        ram_raddr = k_q;
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d.sorted_word   = ram_rdata;
          out_d.end_of_batch  = eob;
          out_d.words_dropped = ovf_q;
          if (eob) begin
            count_d = '0;
            ovf_d   = 1'b0;
            state_d = S_LOAD;
          end else begin
            k_d       = k_q + AW'(1);
            ram_raddr = k_q + AW'(1);
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // Hold control state and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Advance indices and payload, no reset needed
  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    k_q   <= k_d;
    cur_q <= cur_d;
    out_q <= out_d;
  end

endmodule

`default_nettype wire

@@ sv/fwes_checker.sv @@
`default_nettype none
`include "fixed_word_exchange_sorter_core_defines.svh"

module fwes_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_stall_o,
  input wire fwes_pkg::in_t  in_data_i,
  input wire logic           out_valid_o,
  input wire logic           out_stall_i,
  input wire fwes_pkg::out_t out_data_o
);

  logic in_take;

  assign in_take  = in_valid_i && !in_stall_o;

  // Stalled result holds
  `FWES_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result changed")

  // Last word makes the block busy
  `FWES_ASSERT_NEXT(a_busy_after_last, in_take && in_data_i.last, in_stall_o, "input taken right after last word")

  // No new input while a batch is mid-emit
  `FWES_ASSERT_NOW(a_stall_mid_emit, out_valid_o && !out_data_o.end_of_batch, in_stall_o, "input open during emit")

endmodule

bind fixed_word_exchange_sorter_core fwes_checker u_fwes_checker (.*);

`default_nettype wire
